[src/udpdmx_pkg.sv]
// ----------------------------------------------------------------------------
// udpdmx_pkg
// Shared types and constants of the UDP port demultiplexer listener table.
// ----------------------------------------------------------------------------
package udpdmx_pkg;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned PEND_W      = 8;
  localparam logic [PEND_W-1:0] PENDING_MAX = 8'd255;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PEND_W-1:0] pend_t;

  typedef enum logic [1:0] {
    OP_OPEN    = 2'd0,
    OP_CLOSE   = 2'd1,
    OP_DELIVER = 2'd2,
    OP_RECV    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_EXISTS        = 4'd1,
    ST_FULL          = 4'd2,
    ST_INVALID       = 4'd3,
    ST_NO_CONN       = 4'd4,
    ST_WOULD_BLOCK   = 4'd5,
    ST_ERROR         = 4'd6,
    ST_UNREACH       = 4'd7,
    ST_NOPORT_SILENT = 4'd8,
    ST_DROPPED       = 4'd9
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_EXEC,
    S_OUT
  } state_t;

  // compare unit request
  typedef struct packed {
    logic        valid;
    logic [15:0] port;
    logic [31:0] addr;
    logic [15:0] key_port;
    logic [31:0] key_addr;
  } cmp_req_t;

endpackage

[src/udp_port_demux_table_top.sv]
// ----------------------------------------------------------------------------
// udp_port_demux_table_top
// Listener table of a UDP port demultiplexer with recency-ordered lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: open, close,
//   deliver or receive. Output channel (out_valid/out_ready) returns exactly
//   one result beat per command with status, entry, pending count and the
//   three datagram counters. The cfg channel writes iface_address, used as
//   destination of broadcast datagrams; write it only while idle.
//   Open and good deliver walk the search order through one shared compare
//   unit, one entry per cycle, then move the hit or the newly opened entry
//   to the front one position per cycle. Close, receive and a deliver with
//   a bad checksum or short header skip the walk. out_valid is accepted at
//   the earliest in its first cycle and in_ready rises the cycle after. One
//   command is in flight at a time; out_valid holds while out_ready is low
//   and in_ready stays low until the result beat is taken.
//   Reset empties the table, sets the search order to identity and clears
//   the counters and iface_address. No clearing pass is needed.
// ----------------------------------------------------------------------------
module udp_port_demux_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [3:0]  entry,
  input  logic [15:0] port,
  input  logic [31:0] address,
  input  logic        broadcast,
  input  logic        checksum_bad,
  input  logic        header_short,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [3:0]  result_entry,
  output logic [7:0]  pending_count,
  output logic [31:0] in_datagrams,
  output logic [31:0] no_ports,
  output logic [31:0] in_errors
);

  localparam int unsigned IW = udpdmx_pkg::IDX_W;
  localparam int unsigned CW = IW + 1;

  udpdmx_pkg::state_t state, state_next;

  logic [31:0] iface_address;
  logic [udpdmx_pkg::ENTRIES-1:0] entry_valid;
  logic [15:0]              entry_port    [udpdmx_pkg::ENTRIES];
  logic [31:0]              entry_address [udpdmx_pkg::ENTRIES];
  udpdmx_pkg::pend_t        entry_pending [udpdmx_pkg::ENTRIES];
  udpdmx_pkg::idx_t         search_order  [udpdmx_pkg::ENTRIES];
  logic [31:0] accepted_count, noport_count, error_count;

  udpdmx_pkg::op_t   cmd_op;
  logic [IW-1:0]     cmd_entry;
  logic [15:0]       cmd_port;
  logic [31:0]       cmd_addr;
  logic              cmd_bcast;
  logic              cmd_err;
  logic [CW-1:0]     pos;
  logic              found;
  logic [IW-1:0]     hit_idx;

  udpdmx_pkg::cmp_req_t req;
  logic              hit;
  logic [IW-1:0]     cur;
  logic              scan_done;
  logic              free_any;
  logic [IW-1:0]     free_idx;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == udpdmx_pkg::S_IDLE) && !out_valid;

  assign cur = search_order[pos[IW-1:0]];
  assign req.valid    = entry_valid[cur];
  assign req.port     = entry_port[cur];
  assign req.addr     = entry_address[cur];
  assign req.key_port = cmd_port;
  assign req.key_addr = cmd_addr;

  udpdmx_match u_match (.req(req), .hit(hit));

  assign scan_done = hit || (pos == CW'(udpdmx_pkg::ENTRIES - 1));

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = udpdmx_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      udpdmx_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          if ((opcode == udpdmx_pkg::OP_OPEN) ||
              ((opcode == udpdmx_pkg::OP_DELIVER) && !checksum_bad && !header_short)) begin
            state_next = udpdmx_pkg::S_SCAN;
          end else begin
            state_next = udpdmx_pkg::S_EXEC;
          end
        end
      end
      udpdmx_pkg::S_SCAN: begin
        if (hit) begin
          state_next = udpdmx_pkg::S_MOVE;
        end else if (scan_done) begin
          state_next = udpdmx_pkg::S_EXEC;
        end
      end
      udpdmx_pkg::S_MOVE: begin
        if (pos == '0) begin
          state_next = found ? udpdmx_pkg::S_EXEC : udpdmx_pkg::S_OUT;
        end
      end
      udpdmx_pkg::S_EXEC: begin
        if ((cmd_op == udpdmx_pkg::OP_OPEN) && !found && free_any) begin
          state_next = udpdmx_pkg::S_MOVE;
        end else begin
          state_next = udpdmx_pkg::S_OUT;
        end
      end
      udpdmx_pkg::S_OUT: begin
        state_next = udpdmx_pkg::S_IDLE;
      end
      default: state_next = udpdmx_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= udpdmx_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iface_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      iface_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid    <= '0;
      accepted_count <= '0;
      noport_count   <= '0;
      error_count    <= '0;
      out_valid      <= 1'b0;
      found          <= 1'b0;
      pos            <= '0;
      for (int i = 0; i < udpdmx_pkg::ENTRIES; i++) begin
        search_order[i] <= IW'(i);
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        udpdmx_pkg::S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_op    <= udpdmx_pkg::op_t'(opcode);
            cmd_entry <= entry;
            cmd_port  <= port;
            cmd_addr  <= ((opcode == udpdmx_pkg::OP_DELIVER) && broadcast) ?
                         iface_address : address;
            cmd_bcast <= broadcast;
            cmd_err   <= checksum_bad || header_short;
            pos       <= '0;
            found     <= 1'b0;
          end
        end
        udpdmx_pkg::S_SCAN: begin
          if (hit) begin
            found   <= 1'b1;
            hit_idx <= cur;
          end else if (!scan_done) begin
            pos <= pos + CW'(1);
          end
        end
        udpdmx_pkg::S_MOVE: begin
          // move the hit toward the front one slot per cycle
          if (pos == '0) begin
            search_order[0] <= hit_idx;
          end else begin
            search_order[pos[IW-1:0]] <= search_order[pos[IW-1:0] - IW'(1)];
            pos <= pos - CW'(1);
          end
        end
        udpdmx_pkg::S_EXEC: begin
          status        <= udpdmx_pkg::ST_OK;
          result_entry  <= '0;
          pending_count <= '0;
          case (cmd_op)
            udpdmx_pkg::OP_OPEN: begin
              if (found) begin
                status        <= udpdmx_pkg::ST_EXISTS;
                result_entry  <= hit_idx;
                pending_count <= entry_pending[hit_idx];
              end else if (!free_any) begin
                status <= udpdmx_pkg::ST_FULL;
              end else begin
                entry_valid[free_idx]   <= 1'b1;
                entry_port[free_idx]    <= cmd_port;
                entry_address[free_idx] <= cmd_addr;
                entry_pending[free_idx] <= '0;
                result_entry            <= free_idx;
                hit_idx                 <= free_idx;
                pos <= '0;
                for (int i = 0; i < udpdmx_pkg::ENTRIES; i++) begin
                  if (search_order[i] == free_idx) begin
                    pos <= CW'(i);
                  end
                end
              end
            end
            udpdmx_pkg::OP_CLOSE: begin
              if (!entry_valid[cmd_entry]) begin
                status <= udpdmx_pkg::ST_INVALID;
              end else begin
                entry_valid[cmd_entry]   <= 1'b0;
                entry_pending[cmd_entry] <= '0;
                result_entry             <= cmd_entry;
              end
            end
            udpdmx_pkg::OP_DELIVER: begin
              if (cmd_err) begin
                error_count <= error_count + 32'd1;
                status      <= udpdmx_pkg::ST_ERROR;
              end else if (!found) begin
                noport_count <= noport_count + 32'd1;
                status <= cmd_bcast ? udpdmx_pkg::ST_NOPORT_SILENT : udpdmx_pkg::ST_UNREACH;
              end else begin
                result_entry <= hit_idx;
                if (entry_pending[hit_idx] >= udpdmx_pkg::PENDING_MAX) begin
                  status        <= udpdmx_pkg::ST_DROPPED;
                  pending_count <= entry_pending[hit_idx];
                end else begin
                  entry_pending[hit_idx] <= entry_pending[hit_idx] + 8'd1;
                  pending_count          <= entry_pending[hit_idx] + 8'd1;
                  accepted_count         <= accepted_count + 32'd1;
                end
              end
            end
            udpdmx_pkg::OP_RECV: begin
              if (!entry_valid[cmd_entry]) begin
                status <= udpdmx_pkg::ST_NO_CONN;
              end else begin
                result_entry <= cmd_entry;
                if (entry_pending[cmd_entry] == '0) begin
                  status <= udpdmx_pkg::ST_WOULD_BLOCK;
                end else begin
                  entry_pending[cmd_entry] <= entry_pending[cmd_entry] - 8'd1;
                  pending_count            <= entry_pending[cmd_entry] - 8'd1;
                end
              end
            end
            default: status <= udpdmx_pkg::ST_OK;
          endcase
        end
        udpdmx_pkg::S_OUT: begin
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign in_datagrams = accepted_count;
  assign no_ports     = noport_count;
  assign in_errors    = error_count;

endmodule

[src/udpdmx_match.sv]
// ----------------------------------------------------------------------------
// udpdmx_match
// Shared compare unit: one stored listener against the lookup key per cycle.
// ----------------------------------------------------------------------------
module udpdmx_match (
  input  udpdmx_pkg::cmp_req_t req,
  output logic                 hit
);

  assign hit = req.valid && (req.port == req.key_port) &&
               ((req.addr == req.key_addr) || (req.addr == 32'd0));

endmodule
